// ===== design/thumb_alu_subset_with_flags_core_assert.svh =====
// Assertion macros for the Thumb ALU core.
`ifndef THUMB_ALU_SUBSET_WITH_FLAGS_CORE_ASSERT_SVH
`define THUMB_ALU_SUBSET_WITH_FLAGS_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TASF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TASF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/tasf_pkg.sv =====
// Shared constants, opcodes and types of the Thumb ALU core.
package tasf_pkg;

   localparam int DATA_W      = 32;
   localparam int REG_COUNT   = 8;
   localparam int REG_IDX_W   = $clog2(REG_COUNT);
   localparam int IDX_FIELD_W = 3;
   localparam int SHIFT_W     = 6;
   localparam int OP_W        = 4;

   typedef enum logic [OP_W-1:0] {
      OP_MOV,
      OP_ADDS,
      OP_SUBS,
      OP_ANDS,
      OP_ORR,
      OP_XOR,
      OP_LSRS,
      OP_LSLS,
      OP_CMP,
      OP_TST
   } op_type;

   typedef struct packed {
      logic n;
      logic z;
      logic c;
      logic v;
   } flags_type;

   typedef struct packed {
      logic [DATA_W-1:0]    value;
      logic [REG_IDX_W-1:0] index;
      logic                 write_enable;
      flags_type            flags;
   } alu_result_type;

endpackage

// ===== design/tasf_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
module tasf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== design/tasf_alu.sv =====
// Execute logic: result value, write control and next NZCV flags for one instruction.
module tasf_alu (
   input  tasf_pkg::op_type                    op,
   input  logic [tasf_pkg::REG_IDX_W-1:0]      dest_index,
   input  logic [tasf_pkg::DATA_W-1:0]         immediate,
   input  logic [tasf_pkg::SHIFT_W-1:0]        shift_amount,
   input  logic [tasf_pkg::DATA_W-1:0]         opnd_a,
   input  logic [tasf_pkg::DATA_W-1:0]         opnd_b,
   input  tasf_pkg::flags_type                 flags_cur,
   output tasf_pkg::alu_result_type            result
);

   localparam int MSB = tasf_pkg::DATA_W - 1;

   logic [tasf_pkg::DATA_W:0]   sum_ext;
   logic [tasf_pkg::DATA_W:0]   diff_ext;
   logic [tasf_pkg::DATA_W:0]   lsr_ext;
   logic [tasf_pkg::DATA_W:0]   lsl_ext;
   logic [tasf_pkg::DATA_W-1:0] minuend;
   logic [tasf_pkg::DATA_W-1:0] subtrahend;
   logic                        shift_zero;
   logic                        set_nz;

   // cmp subtracts first-source (port a) from the dest register (port b)
   assign minuend    = (op == tasf_pkg::OP_CMP) ? opnd_b : opnd_a;
   assign subtrahend = (op == tasf_pkg::OP_CMP) ? opnd_a : opnd_b;

   assign sum_ext  = {1'b0, opnd_a} + {1'b0, opnd_b};
   assign diff_ext = {1'b0, minuend} - {1'b0, subtrahend};

   // extra bit below (lsr) or above (lsl) catches the last bit shifted out
   assign lsr_ext    = {opnd_a, 1'b0} >> shift_amount;
   assign lsl_ext    = {1'b0, opnd_a} << shift_amount;
   assign shift_zero = (shift_amount == '0);

   always_comb begin
      result.value        = '0;
      result.index        = dest_index;
      result.write_enable = 1'b1;
      result.flags        = flags_cur;
      set_nz              = 1'b1;
      unique case (op)
         tasf_pkg::OP_MOV: begin
            result.value = immediate;
         end
         tasf_pkg::OP_ADDS: begin
            result.value   = sum_ext[MSB:0];
            result.flags.c = sum_ext[tasf_pkg::DATA_W];
            result.flags.v = (opnd_a[MSB] ^ sum_ext[MSB]) & (opnd_b[MSB] ^ sum_ext[MSB]);
         end
         tasf_pkg::OP_SUBS, tasf_pkg::OP_CMP: begin
            result.value        = diff_ext[MSB:0];
            result.flags.c      = ~diff_ext[tasf_pkg::DATA_W];
            result.flags.v      = (minuend[MSB] ^ subtrahend[MSB])
                                  & (minuend[MSB] ^ diff_ext[MSB]);
            result.write_enable = (op != tasf_pkg::OP_CMP);
         end
         tasf_pkg::OP_ANDS: begin
            result.value = opnd_a & opnd_b;
         end
         tasf_pkg::OP_ORR: begin
            result.value = opnd_a | opnd_b;
         end
         tasf_pkg::OP_XOR: begin
            result.value = opnd_a ^ opnd_b;
         end
         tasf_pkg::OP_LSRS: begin
            result.value = lsr_ext[tasf_pkg::DATA_W:1];
            if (!shift_zero) begin
               result.flags.c = lsr_ext[0];
            end
         end
         tasf_pkg::OP_LSLS: begin
            result.value = lsl_ext[MSB:0];
            if (!shift_zero) begin
               result.flags.c = lsl_ext[tasf_pkg::DATA_W];
            end
         end
         tasf_pkg::OP_TST: begin
            result.value        = opnd_a & opnd_b;
            result.write_enable = 1'b0;
         end
         default: begin
            // unused opcode: no write, flags kept
            result.index        = '0;
            result.write_enable = 1'b0;
            set_nz              = 1'b0;
         end
      endcase
      if (set_nz) begin
         result.flags.n = result.value[MSB];
         result.flags.z = (result.value == '0);
      end
   end

endmodule

// ===== design/thumb_alu_subset_with_flags_core.sv =====
// Top level of the Thumb ALU core: handshakes, register file, flags and result register.
//
// Executes one decoded instruction per transfer at a sustained rate of one
// instruction per cycle while rsp_stall is low. An accepted instruction has
// its operands read through the registered read ports of the register-file
// RAM into one execute stage, and its result is then registered in the result
// register. The eight registers live in a two-read, one-write RAM; the result
// register forwards the latest write to the next instruction, and per-register
// valid bits make unwritten registers read as zero right after reset, so no
// clearing pass is needed. A result waiting on rsp_stall still lets one more
// instruction be accepted into the execute stage.
`include "thumb_alu_subset_with_flags_core_assert.svh"

module thumb_alu_subset_with_flags_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_op,
   input  logic [2:0]  req_dest_index,
   input  logic [2:0]  req_first_source,
   input  logic [2:0]  req_second_source,
   input  logic [31:0] req_immediate,
   input  logic [5:0]  req_shift_amount,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_write_value,
   output logic [2:0]  rsp_write_index,
   output logic        rsp_write_enable,
   output logic        rsp_flags_n,
   output logic        rsp_flags_z,
   output logic        rsp_flags_c,
   output logic        rsp_flags_v
);

   localparam int IDX_W = tasf_pkg::REG_IDX_W;
   localparam int DW    = tasf_pkg::DATA_W;

   logic                       accept;
   logic                       s1_move;
   tasf_pkg::op_type           req_op_dec;
   logic [IDX_W-1:0]           rd_addr_a;
   logic [IDX_W-1:0]           rd_addr_b;
   logic [DW-1:0]              ram_data_a;
   logic [DW-1:0]              ram_data_b;
   logic [DW-1:0]              opnd_a;
   logic [DW-1:0]              opnd_b;
   tasf_pkg::alu_result_type   alu_result;

   // execute stage
   logic                       s1_valid_ff,   s1_valid_in;
   tasf_pkg::op_type           s1_op_ff;
   logic [IDX_W-1:0]           s1_dest_ff;
   logic [DW-1:0]              s1_imm_ff;
   logic [tasf_pkg::SHIFT_W-1:0] s1_shift_ff;
   logic [IDX_W-1:0]           s1_addr_a_ff;
   logic [IDX_W-1:0]           s1_addr_b_ff;
   logic                       s1_a_valid_ff;
   logic                       s1_b_valid_ff;

   // architectural state outside the RAM
   tasf_pkg::flags_type        flags_ff,      flags_in;
   logic [tasf_pkg::REG_COUNT-1:0] reg_valid_ff, reg_valid_in;

   // result register, also the forwarding source
   logic                       rsp_valid_ff,  rsp_valid_in;
   logic [DW-1:0]              rsp_value_ff;
   logic [IDX_W-1:0]           rsp_index_ff;
   logic                       rsp_we_ff;
   tasf_pkg::flags_type        rsp_flags_ff;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   assign req_op_dec = tasf_pkg::op_type'(req_op);
   assign rd_addr_a  = req_first_source[IDX_W-1:0];
   // cmp and tst read the dest register on port b, in place of the second source
   assign rd_addr_b  = (req_op_dec == tasf_pkg::OP_CMP || req_op_dec == tasf_pkg::OP_TST)
                       ? req_dest_index[IDX_W-1:0] : req_second_source[IDX_W-1:0];

   tasf_ram #(
      .WIDTH (DW),
      .DEPTH (tasf_pkg::REG_COUNT)
   ) u_regfile (
      .clock     (clock),
      .wr_en     (s1_move && alu_result.write_enable),
      .wr_addr   (alu_result.index),
      .wr_data   (alu_result.value),
      .rd_en     (accept),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (ram_data_a),
      .rd_data_b (ram_data_b)
   );

   // The RAM read at accept misses a write retiring on the same edge; the
   // result register holds that write, and older ones are already in the RAM.
   always_comb begin
      opnd_a = s1_a_valid_ff ? ram_data_a : '0;
      opnd_b = s1_b_valid_ff ? ram_data_b : '0;
      if (rsp_we_ff && rsp_index_ff == s1_addr_a_ff) begin
         opnd_a = rsp_value_ff;
      end
      if (rsp_we_ff && rsp_index_ff == s1_addr_b_ff) begin
         opnd_b = rsp_value_ff;
      end
   end

   tasf_alu u_alu (
      .op           (s1_op_ff),
      .dest_index   (s1_dest_ff),
      .immediate    (s1_imm_ff),
      .shift_amount (s1_shift_ff),
      .opnd_a       (opnd_a),
      .opnd_b       (opnd_b),
      .flags_cur    (flags_ff),
      .result       (alu_result)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      flags_in     = flags_ff;
      reg_valid_in = reg_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_move) begin
         s1_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
         flags_in     = alu_result.flags;
         if (alu_result.write_enable) begin
            reg_valid_in[alu_result.index] = 1'b1;
         end
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_we_ff    <= 1'b0;
         flags_ff     <= '0;
         reg_valid_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
         reg_valid_ff <= reg_valid_in;
         if (s1_move) begin
            rsp_we_ff <= alu_result.write_enable;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff      <= req_op_dec;
         s1_dest_ff    <= req_dest_index[IDX_W-1:0];
         s1_imm_ff     <= req_immediate;
         s1_shift_ff   <= req_shift_amount;
         s1_addr_a_ff  <= rd_addr_a;
         s1_addr_b_ff  <= rd_addr_b;
         s1_a_valid_ff <= reg_valid_ff[rd_addr_a];
         s1_b_valid_ff <= reg_valid_ff[rd_addr_b];
      end
      if (s1_move) begin
         rsp_value_ff <= alu_result.value;
         rsp_index_ff <= alu_result.index;
         rsp_flags_ff <= alu_result.flags;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_value  = rsp_value_ff;
   assign rsp_write_index  = tasf_pkg::IDX_FIELD_W'(rsp_index_ff);
   assign rsp_write_enable = rsp_we_ff;
   assign rsp_flags_n      = rsp_flags_ff.n;
   assign rsp_flags_z      = rsp_flags_ff.z;
   assign rsp_flags_c      = rsp_flags_ff.c;
   assign rsp_flags_v      = rsp_flags_ff.v;

   // every executed instruction shows up as a result transfer
   `TASF_ASSERT_NEXT(a_exec_gives_rsp, clock, reset, s1_move, rsp_valid_ff, "executed item lost")

   // compare and test never write the register file
   `TASF_ASSERT_NOW(a_cmp_tst_no_write, clock, reset, s1_move && (s1_op_ff == tasf_pkg::OP_CMP || s1_op_ff == tasf_pkg::OP_TST), !alu_result.write_enable, "cmp or tst writes")

   // flags only change when an instruction retires
   `TASF_ASSERT_NEXT(a_flags_hold, clock, reset, !s1_move, $stable(flags_ff), "flags changed while idle")

endmodule
